@@ sv/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants of the button press classifier
// Holds the tick record passed from the front end to the event serializer,
// the event kinds and the configuration register indexes.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int NUM_SLOTS   = 2 * NUM_BUTTONS;  // two event slots per button
  localparam int SLOT_W      = $clog2(NUM_SLOTS);
  localparam int BTN_W       = 2;
  localparam int HELD_W      = 16;
  localparam int DEB_W       = 8;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVELS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_0        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_1        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_2        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_3        = 3'd6;

  localparam logic [HELD_W-1:0] HELD_MAX  = 16'hFFFF;
  localparam logic [DEB_W-1:0]  COUNT_MAX = 8'hFF;
  localparam logic [DEB_W-1:0]  DEB_RESET = 8'd50;
  localparam logic [HELD_W-1:0] LONG_RESET = 16'd1000;

  typedef enum logic [1:0] {
    EV_PRESSED  = 2'd0,
    EV_RELEASED = 2'd1,
    EV_LONG     = 2'd2
  } ev_kind_t;

  // One classified tick. Slot 2*i carries the press or release of button i,
  // slot 2*i+1 its long press, so slot order is the order of the events.
  typedef struct packed {
    logic [NUM_SLOTS-1:0]              slot_valid;
    ev_kind_t [NUM_SLOTS-1:0]          kind;
    logic [NUM_SLOTS-1:0][HELD_W-1:0]  held;
    logic [NUM_BUTTONS-1:0]            mask;
  } tick_rec_t;

endpackage

@@ sv/button_press_classifier.sv @@
// ----------------------------------------------------------------------------
// button_press_classifier: debounce and long-press event generator
// Takes one word per millisecond tick with the raw pin levels of four
// buttons and emits one word per pressed, released or long-press event.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  s_*       in         s_tvalid/s_tready  s_tdata[3:0] pin_levels
//  m_*       out        m_tvalid/m_tready  m_tdata: index, kind, held, mask;
//                                          m_tlast marks a tick's last event
//  cfg_*     in         cfg_we             cfg_index, cfg_data
//
// A tick is classified in the cycle it is accepted, so a new tick can be
// taken every cycle while the record queue has room. Events leave one per
// cycle from the output register unless m_tready stalls them; a tick
// yields zero to eight words. Ticks with no event never enter the queue.
// Reset clears the debounce state, the queue and the output valid flag,
// and loads the configuration reset values. A stall on m_tready backs up
// through the queue to s_tready after QUEUE_DEPTH records.
//
module button_press_classifier #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data,
  // Tick stream.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [bpc_pkg::IN_DATA_W-1:0]  s_tdata,   // [3:0] pin_levels, [7:4] zero
  // Event stream.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bpc_pkg::OUT_DATA_W-1:0] m_tdata,   // [1:0] button_index,
                                                    // [3:2] event_kind,
                                                    // [19:4] held_ticks,
                                                    // [23:20] pressed_mask
  output logic                           m_tlast    // last_event
);
  import bpc_pkg::*;

  tick_rec_t rec, head;
  logic      rec_push, q_full, q_empty, q_pop;
  logic      tick_accept;

  // The queue only refuses a tick when it is full, even if that tick
  // would cause no event.
  assign s_tready    = !q_full;
  assign tick_accept = s_tvalid && s_tready;

  bpc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .tick_valid (tick_accept),
    .pins       (s_tdata[NUM_BUTTONS-1:0]),
    .rec_push   (rec_push),
    .rec        (rec)
  );

  bpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (rec_push),
    .push_rec (rec),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty)
  );

  bpc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (q_empty),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

@@ sv/bpc_front.sv @@
// ----------------------------------------------------------------------------
// bpc_front: tick classifier
// Holds the configuration registers and the per-button debounce state and
// turns each accepted tick into a record of the events it causes.
// ----------------------------------------------------------------------------
module bpc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          tick_valid,
  input  logic [bpc_pkg::NUM_BUTTONS-1:0] pins,
  output logic                          rec_push,
  output bpc_pkg::tick_rec_t            rec
);
  import bpc_pkg::*;

  logic [NUM_BUTTONS-1:0]             active_levels;
  logic [NUM_BUTTONS-1:0]             button_enable;
  logic [DEB_W-1:0]                   debounce_ticks;
  logic [NUM_BUTTONS-1:0][HELD_W-1:0] long_ticks;

  logic [NUM_BUTTONS-1:0]             prev_level, prev_level_next;
  logic [NUM_BUTTONS-1:0]             captured, captured_next;
  logic [NUM_BUTTONS-1:0]             win_active, win_active_next;
  logic [NUM_BUTTONS-1:0][DEB_W-1:0]  win_count, win_count_next;
  logic [NUM_BUTTONS-1:0]             stable, stable_next;
  logic [NUM_BUTTONS-1:0]             long_fired, long_fired_next;
  logic [NUM_BUTTONS-1:0][HELD_W-1:0] held, held_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_levels  <= '0;
      button_enable  <= '0;
      debounce_ticks <= DEB_RESET;
      long_ticks     <= {NUM_BUTTONS{LONG_RESET}};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE_LEVELS: active_levels  <= cfg_data[NUM_BUTTONS-1:0];
        REG_BUTTON_ENABLE: button_enable  <= cfg_data[NUM_BUTTONS-1:0];
        REG_DEBOUNCE:      debounce_ticks <= cfg_data[DEB_W-1:0];
        REG_LONG_0:        long_ticks[0]  <= cfg_data[HELD_W-1:0];
        REG_LONG_1:        long_ticks[1]  <= cfg_data[HELD_W-1:0];
        REG_LONG_2:        long_ticks[2]  <= cfg_data[HELD_W-1:0];
        REG_LONG_3:        long_ticks[3]  <= cfg_data[HELD_W-1:0];
        default: ;
      endcase
    end
  end

  // Each button is independent; only the slot order ties them together.
  always_comb begin
    logic              lvl;
    logic [HELD_W-1:0] held_inc;
    logic [DEB_W-1:0]  cnt_inc;
    prev_level_next = prev_level;
    captured_next   = captured;
    win_active_next = win_active;
    win_count_next  = win_count;
    stable_next     = stable;
    long_fired_next = long_fired;
    held_next       = held;
    rec             = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      lvl      = pins[i];
      held_inc = (stable[i] && held[i] != HELD_MAX) ? held[i] + 1'b1 : held[i];
      cnt_inc  = (win_count[i] != COUNT_MAX) ? win_count[i] + 1'b1 : win_count[i];
      prev_level_next[i] = lvl;
      if (!button_enable[i]) begin
        captured_next[i]   = 1'b0;
        win_active_next[i] = 1'b0;
        win_count_next[i]  = '0;
        stable_next[i]     = 1'b0;
        long_fired_next[i] = 1'b0;
        held_next[i]       = '0;
      end else begin
        held_next[i] = held_inc;
        if (lvl != prev_level[i]) begin
          captured_next[i]   = lvl;
          win_active_next[i] = 1'b1;
          win_count_next[i]  = '0;
        end else if (win_active[i]) begin
          win_count_next[i] = cnt_inc;
          if (cnt_inc >= debounce_ticks) begin
            win_active_next[i] = 1'b0;
            win_count_next[i]  = '0;
            if (lvl == captured[i]) begin
              if (lvl == active_levels[i] && !stable[i]) begin
                stable_next[i]         = 1'b1;
                held_next[i]           = '0;
                long_fired_next[i]     = 1'b0;
                rec.slot_valid[2*i]    = 1'b1;
                rec.kind[2*i]          = EV_PRESSED;
                rec.held[2*i]          = '0;
              end else if (lvl != active_levels[i] && stable[i]) begin
                stable_next[i]         = 1'b0;
                held_next[i]           = '0;
                long_fired_next[i]     = 1'b0;
                rec.slot_valid[2*i]    = 1'b1;
                rec.kind[2*i]          = EV_RELEASED;
                rec.held[2*i]          = held_inc;
              end
            end
          end
        end
        if (stable_next[i] && !long_fired_next[i] && held_next[i] >= long_ticks[i]) begin
          long_fired_next[i]    = 1'b1;
          rec.slot_valid[2*i+1] = 1'b1;
          rec.kind[2*i+1]       = EV_LONG;
          rec.held[2*i+1]       = held_next[i];
        end
      end
    end
    rec.mask = stable_next;
  end

  assign rec_push = tick_valid && (rec.slot_valid != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level <= '0;
      captured   <= '0;
      win_active <= '0;
      win_count  <= '0;
      stable     <= '0;
      long_fired <= '0;
      held       <= '0;
    end else if (tick_valid) begin
      prev_level <= prev_level_next;
      captured   <= captured_next;
      win_active <= win_active_next;
      win_count  <= win_count_next;
      stable     <= stable_next;
      long_fired <= long_fired_next;
      held       <= held_next;
    end
  end

endmodule

@@ sv/bpc_queue.sv @@
// ----------------------------------------------------------------------------
// bpc_queue: tick record queue
// Small register queue between the classifier and the serializer; the head
// entry is visible without a pop.
// ----------------------------------------------------------------------------
module bpc_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bpc_pkg::tick_rec_t push_rec,
  output logic               full,
  input  logic               pop,
  output bpc_pkg::tick_rec_t head,
  output logic               empty
);
  import bpc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tick_rec_t          entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop && !empty) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

@@ sv/bpc_back.sv @@
// ----------------------------------------------------------------------------
// bpc_back: event serializer
// Walks the head record's valid slots in order into an output register,
// one word per cycle unless stalled; pops the record with its last event.
// ----------------------------------------------------------------------------
module bpc_back (
  input  logic                           clk,
  input  logic                           rst,
  input  bpc_pkg::tick_rec_t             head,
  input  logic                           empty,
  output logic                           pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bpc_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tlast
);
  import bpc_pkg::*;

  logic [NUM_SLOTS-1:0] done;      // slots of the head already sent
  logic [NUM_SLOTS-1:0] avail;
  logic [NUM_SLOTS-1:0] rest;
  logic [SLOT_W-1:0]    sel;
  logic                 emit;

  assign avail = head.slot_valid & ~done;

  always_comb begin
    sel = '0;
    for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
      if (avail[k]) begin
        sel = SLOT_W'(k);
      end
    end
    rest      = avail;
    rest[sel] = 1'b0;
  end

  assign emit = !empty && (!m_tvalid || m_tready);
  assign pop  = emit && (rest == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        done     <= (rest == '0) ? '0 : (head.slot_valid & ~rest);
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {head.mask, head.held[sel], head.kind[sel], sel[SLOT_W-1:1]};
      m_tlast <= (rest == '0);
    end
  end

endmodule

@@ sv/bpc_checker.sv @@
// ----------------------------------------------------------------------------
// bpc_checker: port-level checks for the button press classifier
// Watches the event stream for consistency between kind, held time and the
// pressed mask.
// ----------------------------------------------------------------------------
module bpc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [bpc_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tlast
);
  import bpc_pkg::*;

  logic [BTN_W-1:0]       btn;
  logic [1:0]             kind;
  logic [HELD_W-1:0]      held_t;
  logic [NUM_BUTTONS-1:0] mask;
  logic                   btn_down;

  assign btn      = m_tdata[1:0];
  assign kind     = m_tdata[3:2];
  assign held_t   = m_tdata[19:4];
  assign mask     = m_tdata[23:20];
  assign btn_down = mask[btn];

  // A stalled event word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("event word changed while stalled");

  // Press events report zero held time and a set mask bit.
  a_press: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && kind == EV_PRESSED |-> held_t == '0 && btn_down)
    else $error("pressed event inconsistent");

  // A released button is no longer in the mask.
  a_release: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && kind == EV_RELEASED |-> !btn_down)
    else $error("released event with button still down");

  // Long press only for a button still down, and never an unused kind.
  a_long: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (kind == EV_PRESSED || kind == EV_RELEASED ||
                  (kind == EV_LONG && btn_down)))
    else $error("bad long press or event kind");

  // Nothing is offered right after reset.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("event offered after reset");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
